/* hdl/wsd_pkg.sv */
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

  // Width of the payload length and of the size limit register.
  localparam int unsigned LEN_W = 25;

  // Largest payload length that the block ever accepts (16 MB).
  localparam logic [LEN_W-1:0] FRAME_LIMIT = LEN_W'(16 * 1024 * 1024);

  // Reset value of the size limit register.
  localparam logic [LEN_W-1:0] MAX_PAYLOAD_RST = LEN_W'(65536);

  // Entries in the queue between parser and output stage.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Seven-bit length codes that announce an extended length.
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  // One classified transaction on its way from the parser to the output stage.
  typedef struct packed {
    logic [7:0] data;
    logic [7:0] key;
    logic       valid;
    logic [3:0] opcode;
    logic       eof;
    logic       err;
  } wsd_item_t;

endpackage

/* hdl/wsd_front.sv */
// Header parser: classifies each received byte and queues the results it causes.
module wsd_front
  import wsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       stream_byte_i,
  input  logic             max_payload_we_i,
  input  logic [LEN_W-1:0] max_payload_i,
  output logic             item_push_o,
  output wsd_item_t        item_o
);

  // Parser phases.
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXT16   = 3'd2;
  localparam logic [2:0] PH_EXT64   = 3'd3;
  localparam logic [2:0] PH_MASK    = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_HALT    = 3'd6;

  logic [2:0]       phase_q, phase_d;
  logic [3:0]       opcode_q, opcode_d;
  logic             mask_en_q, mask_en_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             big_q, big_d;
  logic [2:0]       cnt_q, cnt_d;
  logic [31:0]      key_q, key_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic [1:0]       pidx_q, pidx_d;
  logic [LEN_W-1:0] max_q;

  logic             finish;
  logic [LEN_W-1:0] fin_len;
  logic             fin_big;
  logic             fin_err;
  logic [LEN_W-1:0] shifted;
  logic             shifted_big;
  logic [7:0]       key_byte;

  // The length is kept in 25 bits; any bit that would land above them is
  // remembered in a sticky flag, since such a length always fails the check.
  assign shifted     = {len_q[LEN_W-9:0], stream_byte_i};
  assign shifted_big = big_q | (len_q[LEN_W-1:LEN_W-8] != 8'd0);

  // Key byte for the current payload position; the first key byte is the top one.
  always_comb begin
    case (pidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign fin_err = fin_big || (fin_len > FRAME_LIMIT) || (fin_len > max_q);

  // Next-state logic of the parser.
  always_comb begin
    phase_d     = phase_q;
    opcode_d    = opcode_q;
    mask_en_d   = mask_en_q;
    len_d       = len_q;
    big_d       = big_q;
    cnt_d       = cnt_q;
    key_d       = key_q;
    remain_d    = remain_q;
    pidx_d      = pidx_q;
    finish      = 1'b0;
    fin_len     = len_q;
    fin_big     = big_q;
    item_push_o = 1'b0;
    item_o      = '{data: 8'd0, key: 8'd0, valid: 1'b0, opcode: opcode_q,
                    eof: 1'b0, err: 1'b0};

    if (accept_i) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d = stream_byte_i[3:0];
          phase_d  = PH_HDR1;
        end
        PH_HDR1: begin
          mask_en_d = stream_byte_i[7];
          key_d     = 32'd0;
          cnt_d     = 3'd0;
          len_d     = '0;
          big_d     = 1'b0;
          if (stream_byte_i[6:0] == LEN7_EXT16) begin
            phase_d = PH_EXT16;
          end else if (stream_byte_i[6:0] == LEN7_EXT64) begin
            phase_d = PH_EXT64;
          end else begin
            len_d = LEN_W'(stream_byte_i[6:0]);
            if (stream_byte_i[7]) begin
              phase_d = PH_MASK;
            end else begin
              finish  = 1'b1;
              fin_len = LEN_W'(stream_byte_i[6:0]);
              fin_big = 1'b0;
            end
          end
        end
        PH_EXT16, PH_EXT64: begin
          len_d = shifted;
          big_d = shifted_big;
          if (cnt_q == ((phase_q == PH_EXT16) ? 3'd1 : 3'd7)) begin
            cnt_d = 3'd0;
            if (mask_en_q) begin
              phase_d = PH_MASK;
            end else begin
              finish  = 1'b1;
              fin_len = shifted;
              fin_big = shifted_big;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_MASK: begin
          key_d = {key_q[23:0], stream_byte_i};
          if (cnt_q == 3'd3) begin
            cnt_d  = 3'd0;
            finish = 1'b1;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          pidx_d      = pidx_q + 2'd1;
          remain_d    = remain_q - LEN_W'(1);
          item_push_o = 1'b1;
          item_o.data  = stream_byte_i;
          item_o.key   = mask_en_q ? key_byte : 8'd0;
          item_o.valid = 1'b1;
          item_o.eof   = (remain_q == LEN_W'(1));
          if (remain_q == LEN_W'(1)) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          // Halted after an oversized frame: bytes are dropped.
        end
      endcase

      // Header complete: check the size, then start the payload or report.
      if (finish) begin
        if (fin_err) begin
          phase_d     = PH_HALT;
          item_push_o = 1'b1;
          item_o.err  = 1'b1;
        end else if (fin_len == '0) begin
          phase_d     = PH_HDR0;
          item_push_o = 1'b1;
          item_o.eof  = 1'b1;
        end else begin
          remain_d = fin_len;
          pidx_d   = 2'd0;
          phase_d  = PH_PAYLOAD;
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      opcode_q  <= 4'd0;
      mask_en_q <= 1'b0;
      len_q     <= '0;
      big_q     <= 1'b0;
      cnt_q     <= 3'd0;
      key_q     <= 32'd0;
      remain_q  <= '0;
      pidx_q    <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      opcode_q  <= opcode_d;
      mask_en_q <= mask_en_d;
      len_q     <= len_d;
      big_q     <= big_d;
      cnt_q     <= cnt_d;
      key_q     <= key_d;
      remain_q  <= remain_d;
      pidx_q    <= pidx_d;
    end
  end

  // Size limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAX_PAYLOAD_RST;
    end else if (max_payload_we_i) begin
      max_q <= max_payload_i;
    end
  end

endmodule

/* hdl/wsd_queue.sv */
// Short queue of classified transactions between the parser and the output stage.
module wsd_queue
  import wsd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  wsd_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output wsd_item_t item_o
);

  wsd_item_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage; entries carry no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

/* hdl/wsd_back.sv */
// Output stage: unmasks queued transactions and holds the oldest result for the receiver.
module wsd_back
  import wsd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  wsd_item_t  q_item_i,
  output logic       q_pop_o,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] data_byte_o,
  output logic       byte_valid_o,
  output logic [3:0] frame_opcode_o,
  output logic       end_of_frame_o,
  output logic       frame_error_o
);

  logic       out_valid_q;
  logic [7:0] data_q;
  logic       bvalid_q;
  logic [3:0] opcode_q;
  logic       eof_q;
  logic       err_q;
  logic       load;

  // Refill the output register when it is free or being taken this cycle.
  assign load    = q_valid_i && (!out_valid_q || pop);
  assign q_pop_o = load;
  assign empty   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, unmasked on the way in.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q   <= q_item_i.data ^ q_item_i.key;
      bvalid_q <= q_item_i.valid;
      opcode_q <= q_item_i.opcode;
      eof_q    <= q_item_i.eof;
      err_q    <= q_item_i.err;
    end
  end

  assign data_byte_o    = data_q;
  assign byte_valid_o   = bvalid_q;
  assign frame_opcode_o = opcode_q;
  assign end_of_frame_o = eof_q;
  assign frame_error_o  = err_q;

endmodule

/* hdl/websocket_frame_deframer_unit.sv */
// WebSocket frame deframer: top level joining parser, queue and output stage.
//
// Usage: received connection bytes are written on stream_byte_i with push; a
// byte is taken at a clock edge where push is high and full is low. Results
// are read like a queue: while empty is low the oldest result is on the
// result ports, and it is taken at an edge where pop is high. Header bytes
// give no result, except the byte that completes the header of an empty or
// an oversized frame, which gives an empty-frame marker or an error. Each
// payload byte gives one unmasked byte; the last one carries end_of_frame_o.
// Throughput is one byte per cycle while full is low. Each result is written
// into the queue at the edge that accepts its byte, and the output register
// loads the oldest one when it is free or being taken by pop. A four-entry
// queue plus the output register absorb a stalled receiver; once they are
// all occupied, full stays high until pop frees one.
// The size limit is written through max_payload_we_i / max_payload_i and
// resets to 65536. After a frame that is too long the single error result is
// queued and all further bytes are dropped until reset. Reset empties the
// queue and returns the parser to the first header byte.
module websocket_frame_deframer_unit
  import wsd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       stream_byte_i,
  input  logic             max_payload_we_i,
  input  logic [LEN_W-1:0] max_payload_i,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       data_byte_o,
  output logic             byte_valid_o,
  output logic [3:0]       frame_opcode_o,
  output logic             end_of_frame_o,
  output logic             frame_error_o
);

  logic      accept;
  logic      f_push;
  wsd_item_t f_item;
  logic      q_valid;
  wsd_item_t q_item;
  logic      q_pop;

  assign accept = push && !full;

  // Front: header parsing and byte classification.
  wsd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .stream_byte_i   (stream_byte_i),
    .max_payload_we_i(max_payload_we_i),
    .max_payload_i   (max_payload_i),
    .item_push_o     (f_push),
    .item_o          (f_item)
  );

  // Decoupling queue.
  wsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_push),
    .item_i (f_item),
    .full_o (full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .item_o (q_item)
  );

  // Back: unmasking and result register.
  wsd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .pop           (pop),
    .empty         (empty),
    .data_byte_o   (data_byte_o),
    .byte_valid_o  (byte_valid_o),
    .frame_opcode_o(frame_opcode_o),
    .end_of_frame_o(end_of_frame_o),
    .frame_error_o (frame_error_o)
  );

endmodule

/* hdl/wsd_checker.sv */
// Port-level checks of the deframer and their binding to the top level.
module wsd_checker
  import wsd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte_o,
  input logic       byte_valid_o,
  input logic       end_of_frame_o,
  input logic       frame_error_o
);

  // A result without a payload byte carries a zero data byte.
  a_nodata_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> (data_byte_o == 8'd0))
    else $error("non-data result has nonzero data byte");

  // An error result is neither a data byte nor an end of frame.
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_error_o) |-> (!byte_valid_o && !end_of_frame_o))
    else $error("error result carries data or end of frame");

  // The error is the last result before reset.
  a_halt_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && frame_error_o) |=> empty)
    else $error("result delivered after an error");

  // A stalled result holds its data.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_byte_o)))
    else $error("stalled result changed");

endmodule

bind websocket_frame_deframer_unit wsd_checker u_wsd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .data_byte_o   (data_byte_o),
  .byte_valid_o  (byte_valid_o),
  .end_of_frame_o(end_of_frame_o),
  .frame_error_o (frame_error_o)
);

/* sim/websocket_frame_deframer_unit_tb.sv */
// Self-checking testbench for the WebSocket frame deframer top level.
module websocket_frame_deframer_unit_tb;
  import wsd_pkg::*;

  localparam int unsigned NDIR = 28;
  localparam int unsigned RAND_ITEMS = 850;
  localparam int unsigned RX_HOLD = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result transaction as seen on the output ports.
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [3:0] opcode;
    logic       eof;
    logic       err;
  } frame_result_t;

  // One directed byte, with an optional hand-written expected result.
  typedef struct packed {
    logic [7:0]    b;
    logic          typed;
    frame_result_t res;
  } stim_row_t;

  typedef enum logic [2:0] {
    PARSE_HDR0, PARSE_HDR1, PARSE_EXT16, PARSE_EXT64, PARSE_MASK, PARSE_PAYLOAD, PARSE_HALT
  } parse_state_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             push = 1'b0;
  logic             full;
  logic [7:0]       stream_byte_i = '0;
  logic             max_payload_we_i = 1'b0;
  logic [LEN_W-1:0] max_payload_i = '0;
  logic             empty;
  logic             pop = 1'b0;
  logic [7:0]       data_byte_o;
  logic             byte_valid_o;
  logic [3:0]       frame_opcode_o;
  logic             end_of_frame_o;
  logic             frame_error_o;

  // Typed expectation that travels with the byte being offered.
  logic          typed_on = 1'b0;
  frame_result_t typed_res = '0;

  // Deframer state as predicted from the accepted bytes.
  parse_state_e     ps = PARSE_HDR0;
  logic [3:0]       cur_op = '0;
  logic             masked = 1'b0;
  logic [63:0]      len_acc = '0;
  logic [2:0]       hcnt = '0;
  logic [31:0]      mkey = '0;
  logic [LEN_W-1:0] remaining = '0;
  logic [1:0]       pidx = '0;
  logic [LEN_W-1:0] size_limit = MAX_PAYLOAD_RST;

  frame_result_t pending_results[$];
  int unsigned   accepted_bytes = 0;
  int unsigned   cycle_count = 0;
  bit            failed = 1'b0;
  bit            tx_steady = 1'b0;
  bit            rx_steady = 1'b0;
  bit            rx_hold_req = 1'b0;

  // Directed bytes: empty frame, flagged header, masked frame, 64-bit length.
  stim_row_t directed_rows [NDIR] = '{
    '{8'h81, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, 1'b0, 4'h1, 1'b1, 1'b0}},
    '{8'hF2, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b1, '{8'hFF, 1'b1, 4'h2, 1'b1, 1'b0}},
    '{8'h0F, 1'b0, '0},
    '{8'h85, 1'b0, '0},
    '{8'hAA, 1'b0, '0},
    '{8'h55, 1'b0, '0},
    '{8'h0F, 1'b0, '0},
    '{8'hF0, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'hC3, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h02, 1'b0, '0},
    '{8'h11, 1'b1, '{8'h11, 1'b1, 4'h0, 1'b0, 1'b0}},
    '{8'h22, 1'b1, '{8'h22, 1'b1, 4'h0, 1'b1, 1'b0}}
  };

  websocket_frame_deframer_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .stream_byte_i    (stream_byte_i),
    .max_payload_we_i (max_payload_we_i),
    .max_payload_i    (max_payload_i),
    .empty            (empty),
    .pop              (pop),
    .data_byte_o      (data_byte_o),
    .byte_valid_o     (byte_valid_o),
    .frame_opcode_o   (frame_opcode_o),
    .end_of_frame_o   (end_of_frame_o),
    .frame_error_o    (frame_error_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The header is complete: decide between error, empty marker and payload.
  function automatic void close_header(output bit got, output frame_result_t r);
    got = 1'b1;
    r = '0;
    r.opcode = cur_op;
    if (len_acc > 64'(FRAME_LIMIT) || len_acc > 64'(size_limit)) begin
      ps = PARSE_HALT;
      r.err = 1'b1;
    end else if (len_acc == 64'd0) begin
      ps = PARSE_HDR0;
      r.eof = 1'b1;
    end else begin
      got = 1'b0;
      remaining = len_acc[LEN_W-1:0];
      pidx = '0;
      ps = PARSE_PAYLOAD;
    end
  endfunction

  // Advances the predicted parser by one byte and returns its result, if any.
  function automatic void deframe_byte(input logic [7:0] b, output bit got,
                                       output frame_result_t r);
    logic [6:0] len7;
    logic [7:0] key;
    got = 1'b0;
    r = '0;
    case (ps)
      PARSE_HDR0: begin
        cur_op = b[3:0];
        ps = PARSE_HDR1;
      end
      PARSE_HDR1: begin
        masked = b[7];
        len7 = b[6:0];
        mkey = '0;
        hcnt = '0;
        len_acc = '0;
        if (len7 == LEN7_EXT16) begin
          ps = PARSE_EXT16;
        end else if (len7 == LEN7_EXT64) begin
          ps = PARSE_EXT64;
        end else begin
          len_acc = 64'(len7);
          if (masked) ps = PARSE_MASK;
          else close_header(got, r);
        end
      end
      PARSE_EXT16, PARSE_EXT64: begin
        len_acc = {len_acc[55:0], b};
        if (hcnt == ((ps == PARSE_EXT16) ? 3'd1 : 3'd7)) begin
          hcnt = '0;
          if (masked) ps = PARSE_MASK;
          else close_header(got, r);
        end else begin
          hcnt = hcnt + 3'd1;
        end
      end
      PARSE_MASK: begin
        mkey = {mkey[23:0], b};
        if (hcnt == 3'd3) begin
          hcnt = '0;
          close_header(got, r);
        end else begin
          hcnt = hcnt + 3'd1;
        end
      end
      PARSE_PAYLOAD: begin
        key = masked ? mkey[8 * (3 - pidx) +: 8] : 8'h00;
        pidx = pidx + 2'd1;
        remaining = remaining - LEN_W'(1);
        got = 1'b1;
        r.data = b ^ key;
        r.valid = 1'b1;
        r.opcode = cur_op;
        r.eof = (remaining == '0);
        if (remaining == '0) ps = PARSE_HDR0;
      end
      default: ;
    endcase
  endfunction

  // Predict on each accepted byte, and check each accepted result.
  always @(posedge clk_i) begin
    bit got;
    frame_result_t r;
    frame_result_t act;
    frame_result_t exp_r;
    if (rst_ni) begin
      if (push && !full) begin
        deframe_byte(stream_byte_i, got, r);
        if (typed_on) pending_results.push_back(typed_res);
        else if (got) pending_results.push_back(r);
        accepted_bytes++;
      end
      if (pop && !empty) begin
        act = '{data_byte_o, byte_valid_o, frame_opcode_o, end_of_frame_o, frame_error_o};
        if (pending_results.size() == 0) begin
          $error("unexpected result transaction: data_byte %0h", act.data);
          failed = 1'b1;
        end else begin
          exp_r = pending_results.pop_front();
          if (act.data !== exp_r.data) begin
            $error("data_byte: expected %0h, actual %0h", exp_r.data, act.data);
            failed = 1'b1;
          end
          if (act.valid !== exp_r.valid) begin
            $error("byte_valid: expected %0h, actual %0h", exp_r.valid, act.valid);
            failed = 1'b1;
          end
          if (act.opcode !== exp_r.opcode) begin
            $error("frame_opcode: expected %0h, actual %0h", exp_r.opcode, act.opcode);
            failed = 1'b1;
          end
          if (act.eof !== exp_r.eof) begin
            $error("end_of_frame: expected %0h, actual %0h", exp_r.eof, act.eof);
            failed = 1'b1;
          end
          if (act.err !== exp_r.err) begin
            $error("frame_error: expected %0h, actual %0h", exp_r.err, act.err);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input frame_result_t res = '0);
    int unsigned gap;
    gap = tx_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    stream_byte_i <= b;
    typed_on <= typed;
    typed_res <= res;
    do @(posedge clk_i); while (!(push && !full));
  endtask

  // Sends one well-formed frame with random header bits, mask and payload.
  task automatic send_frame(input int unsigned len);
    logic        use_mask;
    logic [31:0] key;
    logic [63:0] len64;
    int unsigned form;
    use_mask = 1'($urandom_range(0, 1));
    key = $urandom;
    len64 = 64'(len);
    // Short lengths sometimes take a longer encoding than they need.
    if (len > 65535) form = 2;
    else if (len > 125) form = $urandom_range(1, 2);
    else form = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
    send_byte(8'($urandom));
    case (form)
      0: send_byte({use_mask, len64[6:0]});
      1: begin
        send_byte({use_mask, LEN7_EXT16});
        send_byte(len64[15:8]);
        send_byte(len64[7:0]);
      end
      default: begin
        send_byte({use_mask, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len64[8 * i +: 8]);
      end
    endcase
    if (use_mask) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
    repeat (len) send_byte(8'($urandom));
  endtask

  // Stops offering and waits until the block has nothing left in flight.
  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_size_limit(input logic [LEN_W-1:0] value);
    @(negedge clk_i);
    max_payload_we_i <= 1'b1;
    max_payload_i <= value;
    size_limit = value;
    @(negedge clk_i);
    max_payload_we_i <= 1'b0;
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off.
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (RX_HOLD) @(negedge clk_i);
      end
      w = rx_steady ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        @(negedge clk_i);
        pop <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (!(pop && !empty));
      if ($urandom_range(0, 31) == 0) rx_steady = ($urandom_range(0, 2) == 0);
    end
  end

  // Main sequence: directed bytes, random phases, then the oversized frame.
  initial begin
    int unsigned      phase_no;
    int unsigned      cap;
    int unsigned      len;
    logic [LEN_W-1:0] lim;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed bytes run under the reset value of the size limit.
    foreach (directed_rows[i])
      send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].res);
    settle();

    // Each phase sets a new size limit and sends frames that fit it.
    phase_no = 0;
    while (accepted_bytes < NDIR + RAND_ITEMS) begin
      case (phase_no)
        0: lim = '0;
        1: lim = FRAME_LIMIT;
        default: begin
          case ($urandom_range(0, 3))
            0: lim = LEN_W'($urandom_range(1, 16));
            1: lim = LEN_W'($urandom_range(17, 2000));
            2: lim = MAX_PAYLOAD_RST;
            default: lim = FRAME_LIMIT;
          endcase
        end
      endcase
      write_size_limit(lim);
      if (phase_no == 2) rx_hold_req = 1'b1;
      repeat ($urandom_range(6, 12)) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        cap = (lim < 40) ? lim : 40;
        if ($urandom_range(0, 15) == 0) cap = (lim < 600) ? lim : 600;
        len = ($urandom_range(0, 5) == 0) ? cap : $urandom_range(0, cap);
        send_frame(len);
      end
      settle();
      phase_no++;
    end

    // The reserved top bit of a 64-bit length must trip the size check;
    // the parser then drops every further byte.
    write_size_limit(FRAME_LIMIT);
    tx_steady = 1'b0;
    send_byte(8'($urandom));
    send_byte({1'b1, LEN7_EXT64});
    send_byte(8'h80);
    repeat (7) send_byte(8'($urandom));
    repeat (4) send_byte(8'($urandom));
    repeat (12) send_byte(8'($urandom));
    settle();

    if (failed) begin
      $display("status: fail");
    end else begin
      $display("status: pass");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/wsd_pkg.sv
hdl/wsd_front.sv
hdl/wsd_queue.sv
hdl/wsd_back.sv
hdl/websocket_frame_deframer_unit.sv
hdl/wsd_checker.sv
sim/websocket_frame_deframer_unit_tb.sv
